// ===== rtl/avr_pkg.sv =====
// Shared types, constants and the arctangent table for the axis-angle rotator.
package avr_pkg;

  localparam int AngW = 17;
  localparam logic signed [AngW-1:0] TurnUnits    = 17'sd23040;
  localparam logic signed [AngW-1:0] HalfTurn     = 17'sd11520;
  localparam logic signed [AngW-1:0] QuarterTurn  = 17'sd5760;
  localparam int XyW = 34;
  localparam int ZW  = 32;
  localparam logic signed [XyW-1:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic                  vld;
    logic                  flip;
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] kx;
    logic signed [15:0] ky;
    logic signed [15:0] kz;
  } vk_t;

  // atan(2^-i) in degrees, in units of 2^-22 degree.
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 32'sd188743680;
      1:  a = 32'sd111421900;
      2:  a = 32'sd58872272;
      3:  a = 32'sd29884485;
      4:  a = 32'sd15000234;
      5:  a = 32'sd7507429;
      6:  a = 32'sd3754631;
      7:  a = 32'sd1877430;
      8:  a = 32'sd938729;
      9:  a = 32'sd469366;
      10: a = 32'sd234683;
      11: a = 32'sd117342;
      12: a = 32'sd58671;
      13: a = 32'sd29335;
      14: a = 32'sd14668;
      15: a = 32'sd7334;
      16: a = 32'sd3667;
      17: a = 32'sd1833;
      18: a = 32'sd917;
      19: a = 32'sd458;
      20: a = 32'sd229;
      21: a = 32'sd115;
      22: a = 32'sd57;
      23: a = 32'sd29;
      24: a = 32'sd14;
      25: a = 32'sd7;
      26: a = 32'sd4;
      27: a = 32'sd2;
      28: a = 32'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/avr_cordic_stage.sv =====
// One registered rotation-mode CORDIC iteration.
module avr_cordic_stage
  import avr_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cordic_t stage_i,
  output cordic_t stage_o
);

  localparam logic signed [ZW-1:0] Atan = atan_deg(SHIFT);

  cordic_t stage_d, stage_q;

  always_comb begin
    stage_d = stage_i;
    if (stage_i.z >= 0) begin
      stage_d.x = stage_i.x - (stage_i.y >>> SHIFT);
      stage_d.y = stage_i.y + (stage_i.x >>> SHIFT);
      stage_d.z = stage_i.z - Atan;
    end else begin
      stage_d.x = stage_i.x + (stage_i.y >>> SHIFT);
      stage_d.y = stage_i.y - (stage_i.x >>> SHIFT);
      stage_d.z = stage_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== rtl/axis_angle_vector_rotate.sv =====
// Top level: pipelined Rodrigues rotation of a vector about an axis by an angle.
// Throughput: one transaction per cycle; busy is always low since nothing ever stalls.
// The rate is set by the fully unrolled CORDIC, one iteration per register stage.
// Reset clears every valid bit, so no done_o strobe appears until a new transaction.
module axis_angle_vector_rotate
  import avr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic signed [15:0] angle_i,
  output logic               done_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o
);

  localparam int N     = CORDIC_STEPS;
  localparam int CsW   = 20;   // cos, sin and 1 - cos in Q16, with headroom
  localparam int PW    = 32;   // 16 x 16 products
  localparam int DotW  = 34;
  localparam int KdW   = 50;
  localparam int AccW  = 72;

  // The pipeline never stalls, so a transaction is taken whenever start is high.
  assign busy = 1'b0;

  // Angle reduction into [-90, 90] degrees, with a flag to negate cos and sin.
  logic signed [AngW-1:0] ang_w, r_a, r_b, r_c;
  logic                   flip_w;
  cordic_t                s0_d, s0_q;

  always_comb begin
    ang_w = AngW'(angle_i);
    // Truncating remainder by one turn; the input magnitude is less than two turns.
    if (ang_w >= TurnUnits) begin
      r_a = ang_w - TurnUnits;
    end else if (ang_w <= -TurnUnits) begin
      r_a = ang_w + TurnUnits;
    end else begin
      r_a = ang_w;
    end
    if (r_a >= HalfTurn) begin
      r_b = r_a - TurnUnits;
    end else if (r_a < -HalfTurn) begin
      r_b = r_a + TurnUnits;
    end else begin
      r_b = r_a;
    end
    flip_w = 1'b0;
    if (r_b > QuarterTurn) begin
      r_c    = r_b - HalfTurn;
      flip_w = 1'b1;
    end else if (r_b < -QuarterTurn) begin
      r_c    = r_b + HalfTurn;
      flip_w = 1'b1;
    end else begin
      r_c = r_b;
    end
    s0_d.vld  = start;
    s0_d.flip = flip_w;
    s0_d.x    = CordicGain;
    s0_d.y    = '0;
    s0_d.z    = ZW'(r_c) <<< 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else begin
      s0_q <= s0_d;
    end
  end

  // Unrolled CORDIC: one iteration per register stage.
  cordic_t chain [0:N];
  assign chain[0] = s0_q;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    avr_cordic_stage #(.SHIFT(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // The vector and the axis ride alongside the CORDIC in a delay line.
  vk_t vk_q [0:N];

  always_ff @(posedge clk_i) begin
    vk_q[0] <= '{vx: vec_x_i, vy: vec_y_i, vz: vec_z_i,
                 kx: axis_x_i, ky: axis_y_i, kz: axis_z_i};
    for (int i = 1; i <= N; i++) begin
      vk_q[i] <= vk_q[i-1];
    end
  end

  // Stage E1: round cos and sin to Q16, negate them when flipped, and form all nine axis-by-vector products.
  logic                  e1_vld_q;
  logic signed [CsW-1:0] e1_c_q, e1_s_q;
  logic signed [PW-1:0]  p_q [0:2][0:2];   // p_q[a][b] = k[a] * v[b]
  vk_t                   e1_vk_q;
  logic signed [XyW-1:0] c_rnd_w, s_rnd_w;

  assign c_rnd_w = (chain[N].x + XyW'(34'sd8192)) >>> 14;
  assign s_rnd_w = (chain[N].y + XyW'(34'sd8192)) >>> 14;

  logic signed [15:0] kv_w [0:2];
  logic signed [15:0] vv_w [0:2];
  assign kv_w[0] = vk_q[N].kx;
  assign kv_w[1] = vk_q[N].ky;
  assign kv_w[2] = vk_q[N].kz;
  assign vv_w[0] = vk_q[N].vx;
  assign vv_w[1] = vk_q[N].vy;
  assign vv_w[2] = vk_q[N].vz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
    end else begin
      e1_vld_q <= chain[N].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_c_q  <= chain[N].flip ? -CsW'(c_rnd_w) : CsW'(c_rnd_w);
    e1_s_q  <= chain[N].flip ? -CsW'(s_rnd_w) : CsW'(s_rnd_w);
    e1_vk_q <= vk_q[N];
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        p_q[a][b] <= PW'(kv_w[a]) * PW'(vv_w[b]);
      end
    end
  end

  // Stage E2: dot product, cross product and 1 - cos.
  logic                   e2_vld_q;
  logic signed [CsW-1:0]  e2_c_q, e2_s_q, e2_omc_q;
  logic signed [DotW-1:0] e2_dot_q;
  logic signed [PW:0]     e2_cr_q [0:2];
  vk_t                    e2_vk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_vld_q <= 1'b0;
    end else begin
      e2_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e2_c_q     <= e1_c_q;
    e2_s_q     <= e1_s_q;
    e2_omc_q   <= CsW'(20'sd65536) - e1_c_q;
    e2_vk_q    <= e1_vk_q;
    e2_dot_q   <= DotW'(p_q[0][0]) + DotW'(p_q[1][1]) + DotW'(p_q[2][2]);
    e2_cr_q[0] <= (PW+1)'(p_q[1][2]) - (PW+1)'(p_q[2][1]);
    e2_cr_q[1] <= (PW+1)'(p_q[2][0]) - (PW+1)'(p_q[0][2]);
    e2_cr_q[2] <= (PW+1)'(p_q[0][1]) - (PW+1)'(p_q[1][0]);
  end

  // Stage E3: the three products per component that need only one multiply each.
  logic                  e3_vld_q;
  logic signed [CsW-1:0] e3_omc_q;
  logic signed [KdW-1:0] e3_kd_q [0:2];
  logic signed [AccW-1:0] e3_t1_q [0:2];
  logic signed [AccW-1:0] e3_t2_q [0:2];

  logic signed [15:0] k2_w [0:2];
  logic signed [15:0] v2_w [0:2];
  assign k2_w[0] = e2_vk_q.kx;
  assign k2_w[1] = e2_vk_q.ky;
  assign k2_w[2] = e2_vk_q.kz;
  assign v2_w[0] = e2_vk_q.vx;
  assign v2_w[1] = e2_vk_q.vy;
  assign v2_w[2] = e2_vk_q.vz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_vld_q <= 1'b0;
    end else begin
      e3_vld_q <= e2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e3_omc_q <= e2_omc_q;
    for (int j = 0; j < 3; j++) begin
      e3_kd_q[j] <= KdW'(k2_w[j]) * KdW'(e2_dot_q);
      e3_t1_q[j] <= AccW'(AccW'(v2_w[j]) * AccW'(e2_c_q)) <<< FRAC_BITS;
      e3_t2_q[j] <= AccW'(e2_cr_q[j]) * AccW'(e2_s_q);
    end
  end

  // Stage E4: rounded k * dot scaled by 1 - cos.
  logic                   e4_vld_q;
  logic signed [AccW-1:0] e4_t1_q [0:2];
  logic signed [AccW-1:0] e4_t2_q [0:2];
  logic signed [AccW-1:0] e4_t3_q [0:2];
  logic signed [KdW-1:0]  kr_w [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      kr_w[j] = (e3_kd_q[j] + (KdW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e4_vld_q <= 1'b0;
    end else begin
      e4_vld_q <= e3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      e4_t1_q[j] <= e3_t1_q[j];
      e4_t2_q[j] <= e3_t2_q[j];
      e4_t3_q[j] <= AccW'(kr_w[j]) * AccW'(e3_omc_q);
    end
  end

  // Stage E5: sum, round away the Q16 trig scale and the fraction bits, then saturate.
  logic                   done_q;
  logic signed [15:0]     out_q [0:2];
  logic signed [AccW-1:0] sum_w [0:2];
  logic signed [15:0]     sat_w [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum_w[j] = (e4_t1_q[j] + e4_t2_q[j] + e4_t3_q[j] + (AccW'(1) <<< (FRAC_BITS + 15)))
                 >>> (FRAC_BITS + 16);
      if (sum_w[j] > AccW'(32767)) begin
        sat_w[j] = 16'sh7FFF;
      end else if (sum_w[j] < -AccW'(32768)) begin
        sat_w[j] = 16'sh8000;
      end else begin
        sat_w[j] = sum_w[j][15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= e4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      out_q[j] <= sat_w[j];
    end
  end

  assign done_o  = done_q;
  assign out_x_o = out_q[0];
  assign out_y_o = out_q[1];
  assign out_z_o = out_q[2];

endmodule

// ===== rtl/avr_checker.sv =====
// Port-level assertions for the axis-angle rotator, bound to the top level.
module avr_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] vec_x_i,
  input logic signed [15:0] vec_y_i,
  input logic signed [15:0] vec_z_i,
  input logic               done_o,
  input logic signed [15:0] out_x_o,
  input logic signed [15:0] out_y_o,
  input logic signed [15:0] out_z_o
);

  localparam int Lat = CORDIC_STEPS + 6;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without a matching transaction");

  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && vec_x_i == 16'sd0 && vec_y_i == 16'sd0 && vec_z_i == 16'sd0)
    |-> ##Lat (out_x_o == 16'sd0 && out_y_o == 16'sd0 && out_z_o == 16'sd0))
    else $error("zero vector did not rotate to zero");

endmodule

bind axis_angle_vector_rotate avr_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_avr_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .vec_x_i (vec_x_i),
  .vec_y_i (vec_y_i),
  .vec_z_i (vec_z_i),
  .done_o  (done_o),
  .out_x_o (out_x_o),
  .out_y_o (out_y_o),
  .out_z_o (out_z_o)
);
